@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the drive mixer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/core/ddm_pkg.sv @@
// Package: widths, codes and shared types of the differential drive mixer
`default_nettype none
package ddm_pkg;
    localparam int SpeedW     = 16;
    localparam int CodeW      = 8;
    localparam int DriveW     = 9;
    localparam int DefEntries = 16;
    localparam logic [15:0] WheelBaseReset = 16'd2048;

    localparam logic OpLoad = 1'b0;
    localparam logic OpMove = 1'b1;

    localparam logic [0:0] RegWheelBase = 1'd0;
    localparam logic [0:0] RegMotors    = 1'd1;

    // Handshake between the control sequencer and the bit-serial divider
    typedef struct packed {
        logic start;
        logic busy;
    } div_ctl_t;
endpackage
`default_nettype wire

@@ rtl/core/differential_drive_mixer.sv @@
// Top level: differential drive inverse kinematics with drive-code lookup
// A move transaction runs a bit-serial division for the turn limit, a
// shift-and-add multiply for the turn term, then two binary searches of at
// most floor(log2(TABLE_ENTRIES))+1 steps, each step a registered table read
// and a compare. A load transaction writes one table entry. The table holds
// whatever was written; a move that reads an entry never loaded returns an
// unspecified code. No new transaction is taken while a result waits in the
// output register.
`default_nettype none
`include "assert_macros.svh"
module differential_drive_mixer
    import ddm_pkg::*;
#(
    parameter int TABLE_ENTRIES = DefEntries
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: entry_index[3:0], entry_speed[19:4], entry_code[27:20],
    //        linear_velocity[43:28], angular_velocity[59:44], zero [63:60]
    input  wire logic [63:0] s_tdata,
    // tuser: op
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: left_drive[8:0], right_drive[17:9], zero [23:18]
    output logic      [23:0] m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);
    localparam int IdxW  = $clog2(TABLE_ENTRIES);
    localparam int StepW = $clog2(IdxW + 2);
    localparam int NumW  = 26;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_DIVW, S_CLAMPW, S_MUL, S_MULW, S_MIX,
        S_SRCH, S_SRD, S_NEXT, S_OUT
    } state_t;

    state_t state_reg;
    logic [15:0] wheel_base_reg;
    logic        motors_reg;

    logic [SpeedW-1:0] speed_mem [TABLE_ENTRIES];
    logic [CodeW-1:0]  code_mem  [TABLE_ENTRIES];
    logic [SpeedW-1:0] rd_speed_reg;
    logic [CodeW-1:0]  rd_code_reg;
    logic [IdxW-1:0]   rd_addr;

    logic [15:0] v_reg, w_reg;
    logic [16:0] av_reg, aw_reg;
    logic        vneg_reg, wneg_reg;
    logic [15:0] vmax_reg;
    logic [16:0] turn_reg;
    logic [17:0] vl_reg, vr_reg;
    logic        side_reg;
    logic [IdxW:0] lo_reg, hi_reg, mid_reg;
    logic [StepW-1:0] step_reg;
    logic        found_reg;
    logic [CodeW-1:0] code_reg;
    logic [DriveW-1:0] left_reg, right_reg;
    logic        out_valid_reg;

    logic        div_start, mul_start;
    div_ctl_t    div_st;
    logic [NumW-1:0] div_q;
    logic        mul_busy;
    logic [32:0] mul_p;
    logic [17:0] cur_speed;
    logic [16:0] cur_mag;
    logic [DriveW-1:0] signed_code;

    // entry 0 sits in the read register while the division starts
    ddm_divider #(.NumW(NumW), .DenW(16)) u_div (
        .aclk, .aresetn, .start(div_start),
        .numerator({1'b0, rd_speed_reg, 9'd0}), .denominator(wheel_base_reg),
        .status(div_st), .quotient(div_q)
    );

    ddm_multiplier #(.AW(16), .BW(17)) u_mul (
        .aclk, .aresetn, .start(mul_start),
        .mcand(wheel_base_reg), .mplier(aw_reg),
        .busy(mul_busy), .product(mul_p)
    );

    assign div_start = (state_reg == S_DIV);
    assign mul_start = (state_reg == S_MUL);
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {6'd0, right_reg, left_reg};

    assign cur_speed = side_reg ? vr_reg : vl_reg;
    assign cur_mag   = cur_speed[17] ? 17'(-cur_speed) : cur_speed[16:0];
    assign rd_addr   = mid_reg[IdxW-1:0];
    assign signed_code = cur_speed[17] ? -{1'b0, code_reg} : {1'b0, code_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_base_reg <= WheelBaseReset;
            motors_reg     <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                RegWheelBase: wheel_base_reg <= cfg_wdata;
                RegMotors:    motors_reg     <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    // table memories: write on load, registered read at the search midpoint
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready && s_tuser == OpLoad
            && {28'd0, s_tdata[3:0]} < 32'(TABLE_ENTRIES)) begin
            speed_mem[IdxW'(s_tdata[3:0])] <= s_tdata[19:4];
            code_mem[IdxW'(s_tdata[3:0])]  <= s_tdata[27:20];
        end
        rd_speed_reg <= speed_mem[rd_addr];
        rd_code_reg  <= code_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    mid_reg <= '0;
                    if (s_tvalid && s_tready && s_tuser == OpMove && motors_reg) begin
                        v_reg     <= s_tdata[43:28];
                        w_reg     <= s_tdata[59:44];
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    // entry 0 has been read by now
                    vmax_reg  <= rd_speed_reg;
                    vneg_reg  <= v_reg[15];
                    wneg_reg  <= w_reg[15];
                    av_reg    <= v_reg[15] ? 17'(-{v_reg[15], v_reg}) : {1'b0, v_reg};
                    aw_reg    <= w_reg[15] ? 17'(-{w_reg[15], w_reg}) : {1'b0, w_reg};
                    state_reg <= S_DIVW;
                end
                S_DIVW: begin
                    if (!div_st.busy && !div_st.start) begin
                        state_reg <= S_CLAMPW;
                    end
                end
                S_CLAMPW: begin
                    if (wheel_base_reg != '0 && {9'd0, aw_reg} > div_q) begin
                        aw_reg <= div_q[16:0];
                    end
                    state_reg <= S_MUL;
                end
                S_MUL: state_reg <= S_MULW;
                S_MULW: begin
                    if (!mul_busy) begin
                        turn_reg  <= mul_p[25:9];
                        state_reg <= S_MIX;
                    end
                end
                S_MIX: begin
                    logic [16:0] lmax;
                    logic [16:0] avc;
                    logic [17:0] vs, ts;
                    lmax = {1'b0, vmax_reg} - turn_reg;
                    avc  = (av_reg > lmax) ? lmax : av_reg;
                    vs   = vneg_reg ? -{1'b0, avc} : {1'b0, avc};
                    ts   = wneg_reg ? -{1'b0, turn_reg} : {1'b0, turn_reg};
                    vr_reg    <= vs + ts;
                    vl_reg    <= vs - ts;
                    side_reg  <= 1'b0;
                    state_reg <= S_SRCH;
                end
                S_SRCH: begin
                    lo_reg    <= '0;
                    hi_reg    <= (IdxW+1)'(TABLE_ENTRIES - 1);
                    mid_reg   <= (IdxW+1)'((TABLE_ENTRIES - 1) / 2);
                    found_reg <= 1'b0;
                    step_reg  <= '0;
                    state_reg <= S_SRD;
                end
                S_SRD: state_reg <= S_NEXT;
                S_NEXT: begin
                    // compare the registered entry at the midpoint
                    logic [IdxW:0] nlo, nhi;
                    nlo = lo_reg;
                    nhi = hi_reg;
                    if (!found_reg) begin
                        code_reg <= rd_code_reg;
                        if ({1'b0, rd_speed_reg} == cur_mag) begin
                            found_reg <= 1'b1;
                        end else if ({1'b0, rd_speed_reg} < cur_mag) begin
                            nhi = mid_reg - 1'b1;
                        end else begin
                            nlo = mid_reg + 1'b1;
                        end
                    end
                    lo_reg <= nlo;
                    hi_reg <= nhi;
                    if (found_reg || ({1'b0, rd_speed_reg} == cur_mag)
                        || $signed({1'b0, nlo}) > $signed({nhi[IdxW], nhi})) begin
                        state_reg <= S_OUT;
                    end else begin
                        mid_reg   <= (nlo + nhi) >> 1;
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= S_SRD;
                    end
                end
                S_OUT: begin
                    logic [DriveW-1:0] c;
                    c = (cur_speed == '0) ? '0 : signed_code;
                    if (!side_reg) begin
                        left_reg  <= c;
                        side_reg  <= 1'b1;
                        state_reg <= S_SRCH;
                    end else begin
                        right_reg     <= -c;
                        out_valid_reg <= 1'b1;
                        mid_reg       <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_hold_out, aclk, aresetn, out_valid_reg, state_reg == S_IDLE)
    `ASSERT_IMPL(a_steps, aclk, aresetn, state_reg == S_NEXT, step_reg <= StepW'(IdxW + 1))
    `ASSERT_IMPL(a_mid_rng, aclk, aresetn, state_reg == S_NEXT,
                 mid_reg < (IdxW+1)'(TABLE_ENTRIES))
endmodule
`default_nettype wire

@@ rtl/core/ddm_divider.sv @@
// Restoring bit-serial divider: one quotient bit per cycle
`default_nettype none
`include "assert_macros.svh"
module ddm_divider
    import ddm_pkg::*;
#(
    parameter int NumW = 26,
    parameter int DenW = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            start,
    input  wire logic [NumW-1:0] numerator,
    input  wire logic [DenW-1:0] denominator,
    output div_ctl_t             status,
    output logic      [NumW-1:0] quotient
);
    localparam int CntW = $clog2(NumW + 1);

    logic [NumW-1:0] num_reg, num_next;
    logic [DenW:0]   rem_reg, rem_next;
    logic [DenW-1:0] den_reg, den_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic [DenW:0]   trial;
    logic [DenW:0]   diff;

    always_comb begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg[DenW-1:0], num_reg[NumW-1]};
        diff      = trial - {1'b0, den_reg};
        if (start) begin
            num_next  = numerator;
            den_next  = denominator;
            rem_next  = '0;
            cnt_next  = CntW'(NumW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift the next numerator bit in and try a subtraction
            if (!diff[DenW]) begin
                rem_next = diff;
                num_next = {num_reg[NumW-2:0], 1'b1};
            end else begin
                rem_next = trial;
                num_next = {num_reg[NumW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        num_reg <= num_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign status.start = start;
    assign status.busy  = busy_reg;
    assign quotient     = num_reg;

    `ASSERT_IMPL(a_cnt_idle, aclk, aresetn, !busy_reg, cnt_reg == '0)
    `ASSERT_NEXT(a_start_busy, aclk, aresetn, start, busy_reg)
    `ASSERT_IMPL(a_rem_lt_den, aclk, aresetn, busy_reg && den_reg != '0, rem_reg < {1'b0, den_reg})
endmodule
`default_nettype wire

@@ rtl/core/ddm_multiplier.sv @@
// Shift-and-add multiplier: one multiplier bit per cycle
`default_nettype none
`include "assert_macros.svh"
module ddm_multiplier
    import ddm_pkg::*;
#(
    parameter int AW = 16,
    parameter int BW = 17
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [AW-1:0]    mcand,
    input  wire logic [BW-1:0]    mplier,
    output logic                  busy,
    output logic      [AW+BW-1:0] product
);
    localparam int CntW = $clog2(BW + 1);

    logic [AW+BW-1:0] acc_reg, acc_next;
    logic [AW+BW-1:0] a_reg, a_next;
    logic [BW-1:0]    b_reg, b_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            acc_next  = '0;
            a_next    = (AW+BW)'(mcand);
            b_next    = mplier;
            cnt_next  = CntW'(BW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[AW+BW-2:0], 1'b0};
            b_next   = {1'b0, b_reg[BW-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign busy    = busy_reg;
    assign product = acc_reg;

    `ASSERT_IMPL(a_mcnt_idle, aclk, aresetn, !busy_reg, cnt_reg == '0)
    `ASSERT_IMPL(a_mcnt_busy, aclk, aresetn, busy_reg, cnt_reg != '0)
    `ASSERT_NEXT(a_mstart, aclk, aresetn, start, busy_reg)
endmodule
`default_nettype wire
